FILE: hdl/lat_pkg.sv
// Shared types and constants for the landmark association table.
package lat_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int REQ_W      = 2;
  localparam int POS_W      = 24;
  localparam int RADIUS_W   = 24;
  localparam int OBS_W      = 16;
  localparam int OUT_IDX_W  = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = RADIUS_W;

  localparam int DIFF_W = POS_W + 1;
  localparam int SQ_W   = 2 * POS_W + 1;
  localparam int DIST_W = SQ_W + 1;
  localparam int LIM_W  = 2 * RADIUS_W;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET  = RADIUS_W'(128);
  localparam logic [OBS_W-1:0]    MIN_OBS_RESET = OBS_W'(15);

  // Candidates for a closest query must lie within this far limit.
  localparam logic [63:0]       FAR_LIMIT_Q8 = 64'd99999 * 64'd256;
  localparam logic [DIST_W-1:0] FAR_SQ       = DIST_W'(FAR_LIMIT_Q8 * FAR_LIMIT_Q8);

  localparam logic [REQ_W-1:0] REQ_ASSOC   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLOSEST = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_OBS = 1'b1;

  typedef struct packed {
    logic load;
    logic insert;
    logic scan;
    logic update;
    logic reply;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             empty;
    logic             scan_last;
    logic             pipe_busy;
    logic             hit;
  } ctrl_status_t;

endpackage

FILE: hdl/lat_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lat_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/lat_ctrl.sv
// Controller state machine sequencing insert, scan, update and reply.
module lat_ctrl import lat_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  ctrl_status_t status,
  output logic         busy,
  output ctrl_cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_INSERT = 7'b0000100,
    S_SCAN   = 7'b0001000,
    S_DRAIN  = 7'b0010000,
    S_UPDATE = 7'b0100000,
    S_REPLY  = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (status.req == REQ_INSERT) begin
          state_next = S_INSERT;
        end else if ((status.req == REQ_ASSOC || status.req == REQ_CLOSEST)
                     && !status.empty) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_REPLY;
        end
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        state_next = S_REPLY;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!status.pipe_busy) begin
          if (status.req == REQ_ASSOC && status.hit) begin
            state_next = S_UPDATE;
          end else begin
            state_next = S_REPLY;
          end
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_REPLY;
      end
      S_REPLY: begin
        cmd.reply  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

FILE: hdl/lat_dp.sv
// Datapath: configuration, entry storage and the pipelined distance scan.
module lat_dp import lat_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_cmd_t             cmd,
  output ctrl_status_t          status,
  input  logic [REQ_W-1:0]      req_type,
  input  logic [POS_W-1:0]      pos_x,
  input  logic [POS_W-1:0]      pos_y,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  done,
  output logic                  found,
  output logic [OUT_IDX_W-1:0]  entry_index,
  output logic [OBS_W-1:0]      times_observed
);

  logic [REQ_W-1:0]    req_q;
  logic [POS_W-1:0]    px_q, py_q;
  logic [RADIUS_W-1:0] radius;
  logic [OBS_W-1:0]    min_obs;
  logic [LIM_W-1:0]    lim;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    scan_addr;

  logic [2*POS_W-1:0]  pos_rd;
  logic [OBS_W-1:0]    obs_rd;

  logic                v1, v2, v3;
  logic [IDX_W-1:0]    idx1, idx2, idx3;
  logic                elig2, elig3;
  logic [OBS_W-1:0]    obs2, obs3;
  logic signed [DIFF_W-1:0]   dx2, dy2;
  logic [SQ_W-1:0]     sqx3, sqy3;
  logic [DIST_W-1:0]   best;
  logic                hit;
  logic [IDX_W-1:0]    res_idx;
  logic [OBS_W-1:0]    res_obs;

  logic                full;
  logic                ins_ok;
  logic signed [DIFF_W-1:0]   diff_x, diff_y;
  logic signed [2*DIFF_W-1:0] prod_x, prod_y;
  logic [DIST_W-1:0]   dist_sum;
  logic                assoc_take, closest_take;
  logic [OBS_W-1:0]    obs_inc;

  logic                obs_we;
  logic [IDX_W-1:0]    obs_waddr;
  logic [OBS_W-1:0]    obs_wdata;

  assign full   = (count == CNT_W'(TABLE_DEPTH));
  assign ins_ok = cmd.insert && !full;

  // Inserts into a non-full table write position and count; an associate hit rewrites the count only.
  assign obs_we    = ins_ok || cmd.update;
  assign obs_waddr = cmd.update ? res_idx : count[IDX_W-1:0];
  assign obs_wdata = cmd.update ? res_obs : OBS_W'(1);

  lat_ram #(.WIDTH(2 * POS_W), .DEPTH(TABLE_DEPTH)) u_pos_ram (
    .clk   (clk),
    .we    (ins_ok),
    .waddr (count[IDX_W-1:0]),
    .wdata ({px_q, py_q}),
    .re    (cmd.scan),
    .raddr (scan_addr[IDX_W-1:0]),
    .rdata (pos_rd)
  );

  lat_ram #(.WIDTH(OBS_W), .DEPTH(TABLE_DEPTH)) u_obs_ram (
    .clk   (clk),
    .we    (obs_we),
    .waddr (obs_waddr),
    .wdata (obs_wdata),
    .re    (cmd.scan),
    .raddr (scan_addr[IDX_W-1:0]),
    .rdata (obs_rd)
  );

  always_comb begin
    diff_x = DIFF_W'($signed(px_q)) - DIFF_W'($signed(pos_rd[2*POS_W-1:POS_W]));
    diff_y = DIFF_W'($signed(py_q)) - DIFF_W'($signed(pos_rd[POS_W-1:0]));
    prod_x = (2*DIFF_W)'(dx2) * (2*DIFF_W)'(dx2);
    prod_y = (2*DIFF_W)'(dy2) * (2*DIFF_W)'(dy2);
    dist_sum = DIST_W'(sqx3) + DIST_W'(sqy3);
    obs_inc = (obs3 == {OBS_W{1'b1}}) ? obs3 : obs3 + OBS_W'(1);
    assoc_take   = v3 && (req_q == REQ_ASSOC) && !hit && (dist_sum < DIST_W'(lim));
    closest_take = v3 && (req_q == REQ_CLOSEST) && elig3 && (dist_sum < best);
  end

  // Configuration registers and the squared radius.
  always_ff @(posedge clk) begin
    if (rst) begin
      radius  <= RADIUS_RESET;
      min_obs <= MIN_OBS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RADIUS:  radius  <= cfg_data[RADIUS_W-1:0];
        CFG_MIN_OBS: min_obs <= cfg_data[OBS_W-1:0];
      endcase
    end
    lim <= LIM_W'(radius) * LIM_W'(radius);
  end

  // Control state: entry count, scan pipeline valids and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      scan_addr <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      hit       <= 1'b0;
      done      <= 1'b0;
    end else begin
      v1   <= cmd.scan;
      v2   <= v1;
      v3   <= v2;
      done <= cmd.reply;
      if (cmd.load) begin
        scan_addr <= '0;
        hit       <= 1'b0;
      end else if (cmd.scan) begin
        scan_addr <= scan_addr + CNT_W'(1);
      end
      if (ins_ok) begin
        count <= count + CNT_W'(1);
        hit   <= 1'b1;
      end
      if (assoc_take || closest_take) begin
        hit <= 1'b1;
      end
    end
  end

  // Payload registers of the request, the scan stages and the result.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req_type;
      px_q  <= pos_x;
      py_q  <= pos_y;
      best  <= FAR_SQ;
    end
    idx1  <= scan_addr[IDX_W-1:0];
    idx2  <= idx1;
    dx2   <= diff_x;
    dy2   <= diff_y;
    obs2  <= obs_rd;
    elig2 <= (obs_rd > min_obs);
    idx3  <= idx2;
    obs3  <= obs2;
    elig3 <= elig2;
    sqx3  <= prod_x[SQ_W-1:0];
    sqy3  <= prod_y[SQ_W-1:0];
    if (ins_ok) begin
      res_idx <= count[IDX_W-1:0];
      res_obs <= OBS_W'(1);
    end
    if (assoc_take) begin
      res_idx <= idx3;
      res_obs <= obs_inc;
    end
    if (closest_take) begin
      best    <= dist_sum;
      res_idx <= idx3;
      res_obs <= obs3;
    end
    if (cmd.reply) begin
      found          <= hit;
      entry_index    <= hit ? OUT_IDX_W'(res_idx) : '0;
      times_observed <= hit ? res_obs : '0;
    end
  end

  always_comb begin
    status.req       = req_q;
    status.empty     = (count == '0);
    status.scan_last = (scan_addr == count - CNT_W'(1));
    status.pipe_busy = v1 || v2 || v3;
    status.hit       = hit;
  end

endmodule

FILE: hdl/landmark_association_table.sv
// Top level of the landmark association table: controller plus datapath.
//
//   channel | handshake                  | payload
//   --------+----------------------------+--------------------------------------
//   request | start, busy                | req_type, pos_x, pos_y
//   result  | done (one-cycle strobe)    | found, entry_index, times_observed
//   config  | cfg_valid, cfg_ready       | cfg_index, cfg_data
//
// An insert passes the decode, insert and reply states before done rises.
// Associate and closest scan the n stored entries through the entry RAM
// read port, one per cycle, behind a pipelined distance computation; done
// rises once the scan has drained, after a count update on an associate
// hit. busy falls in the same cycle as done rises, so start is taken then.
// Reset clears the table and loads the default radius and minimum count.
// The result is shown for one cycle only; the receiver cannot stall it.
module landmark_association_table import lat_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [REQ_W-1:0]      req_type,
  input  logic [POS_W-1:0]      pos_x,
  input  logic [POS_W-1:0]      pos_y,
  output logic                  done,
  output logic                  found,
  output logic [OUT_IDX_W-1:0]  entry_index,
  output logic [OBS_W-1:0]      times_observed,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  assign cfg_ready = 1'b1;

  lat_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  lat_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .req_type       (req_type),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .done           (done),
    .found          (found),
    .entry_index    (entry_index),
    .times_observed (times_observed)
  );

endmodule
